/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition holds at every edge outside reset
`define SSD_ASSERT(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// condition in one cycle implies consequence in the next
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSD_ASSERT(label, clk, rst, cond, msg)
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/ssd_pkg.sv */
package ssd_pkg;

   localparam int OP_W     = 3;
   localparam int KEY_W    = 64;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int LIST_W   = 2;
   localparam int COUNT_W  = 6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD       = 3'd0,
      OP_REMOVE    = 3'd1,
      OP_LOOKUP    = 3'd2,
      OP_READ      = 3'd3,
      OP_DIFF_ELEM = 3'd4,
      OP_DIFF_END  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_MISS    = 2'd1,
      ST_FULL    = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

   typedef enum logic [LIST_W-1:0] {
      DL_NONE  = 2'd0,
      DL_OURS  = 2'd1,
      DL_OTHER = 2'd2
   } list_type;

   typedef enum logic {
      BK_RUN  = 1'b0,
      BK_SCAN = 1'b1
   } back_state_type;

   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [POS_W-1:0]   pos;
   } cmd_type;

   typedef struct packed {
      status_type           status;
      logic                 found;
      logic [POS_W-1:0]     position;
      logic [KEY_W-1:0]     key;
      list_type             diff_list;
      logic                 last;
      logic [COUNT_W-1:0]   count;
   } rsp_type;

endpackage

/* hw/rtl/ssd_if.sv */
interface ssd_req_if;
   logic                        valid;
   logic                        ready;
   logic [ssd_pkg::OP_W-1:0]    operation;
   logic [ssd_pkg::KEY_W-1:0]   key;
   logic [ssd_pkg::POS_W-1:0]   position_in;

   modport source (output valid, output operation, output key, output position_in,
                   input ready);
   modport sink (input valid, input operation, input key, input position_in,
                 output ready);
endinterface

interface ssd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssd_pkg::STATUS_W-1:0]  status;
   logic                          found;
   logic [ssd_pkg::POS_W-1:0]     position_out;
   logic [ssd_pkg::KEY_W-1:0]     key_out;
   logic [ssd_pkg::LIST_W-1:0]    diff_list;
   logic                          last;
   logic [ssd_pkg::COUNT_W-1:0]   count;

   modport source (output valid, output status, output found, output position_out,
                   output key_out, output diff_list, output last, output count,
                   input ready);
   modport sink (input valid, input status, input found, input position_out,
                 input key_out, input diff_list, input last, input count,
                 output ready);
endinterface

/* hw/rtl/small_set_with_symmetric_difference.sv */
// channel   dir   beat payload
// req_bus   in    operation, key, position_in
// rsp_bus   out   status, found, position_out, key_out, diff_list, last, count
//
// add, remove, lookup, read at and diff element finish in the back end without leaving the run state
// diff end steps through the entries up to the last unmarked one, sending one beat per unmarked key
// a two-deep command queue sits between front and back; results leave from a register
// reset is synchronous and clears count, marks, queue and output valid
// a stalled rsp_bus holds the back end; the front keeps taking beats until the queue fills
module small_set_with_symmetric_difference #(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   ssd_req_if.sink     req_bus,
   ssd_rsp_if.source   rsp_bus
);

   logic               cmd_valid;
   logic               cmd_ready;
   ssd_pkg::cmd_type   cmd;

   ssd_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   ssd_back #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* hw/rtl/ssd_front.sv */
module ssd_front #(
   parameter int KEY_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   ssd_req_if.sink           req_bus,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output ssd_pkg::cmd_type  cmd
);

   localparam logic [ssd_pkg::KEY_W-1:0] KeyMask =
      {ssd_pkg::KEY_W{1'b1}} >> (ssd_pkg::KEY_W - KEY_BITS);

   ssd_pkg::cmd_type                 queue_ff [ssd_pkg::QUEUE_DEPTH];
   logic [ssd_pkg::QUEUE_PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ssd_pkg::QUEUE_PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ssd_pkg::QUEUE_CW-1:0]     fill_ff, fill_in;
   logic                             op_known;
   logic                             push;
   logic                             pop;
   ssd_pkg::cmd_type                 new_cmd;

   // undefined codes are taken and dropped
   assign op_known = req_bus.operation inside {[ssd_pkg::OP_ADD : ssd_pkg::OP_DIFF_END]};
   assign req_bus.ready = (fill_ff != ssd_pkg::QUEUE_CW'(ssd_pkg::QUEUE_DEPTH));
   assign push = req_bus.valid && req_bus.ready && op_known;
   assign pop = cmd_valid && cmd_ready;

   assign cmd_valid = (fill_ff != '0);
   assign cmd = queue_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.op = ssd_pkg::op_type'(req_bus.operation);
      new_cmd.key = req_bus.key & KeyMask;
      new_cmd.pos = req_bus.position_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* hw/rtl/ssd_back.sv */
`include "assert_macros.svh"

module ssd_back #(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  ssd_pkg::cmd_type  cmd,
   ssd_rsp_if.source         rsp_bus
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [KEY_BITS-1:0]        keys_ff [CAPACITY];
   logic [CAPACITY-1:0]        marks_ff, marks_in;
   logic [CW-1:0]              count_ff, count_in;
   ssd_pkg::back_state_type    state_ff, state_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic [CAPACITY-1:0]        remain_ff, remain_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ssd_pkg::rsp_type           rsp_ff, rsp_in;

   logic [KEY_BITS-1:0]        cmd_key;
   logic [CAPACITY-1:0]        valid_mask;
   logic [CAPACITY-1:0]        hit;
   logic [CAPACITY-1:0]        ge_mask;
   logic [CAPACITY-1:0]        pending;
   logic [CAPACITY-1:0]        idx_onehot;
   logic                       hit_any;
   logic [IW-1:0]              hit_pos;
   logic                       full;
   logic                       out_free;
   logic                       cmd_fire;
   logic [IW-1:0]              rd_addr;
   logic [KEY_BITS-1:0]        rd_key;
   logic                       pos_ok;
   logic                       scan_here;
   logic                       scan_last;
   logic                       scan_step;
   logic                       scan_emit;
   logic                       add_we;
   logic                       shift_en;

   assign cmd_key = cmd.key[KEY_BITS-1:0];

   // parallel compare against every held key
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         valid_mask[i] = (CW'(i) < count_ff);
         hit[i] = valid_mask[i] && (keys_ff[i] == cmd_key);
         if (hit[i]) begin
            hit_pos = hit_pos | IW'(i);
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         ge_mask[i] = (IW'(i) >= hit_pos);
      end
   end

   assign hit_any = |hit;
   assign pending = ~marks_ff & valid_mask;
   assign full = (count_ff == CW'(CAPACITY));
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign cmd_ready = (state_ff == ssd_pkg::BK_RUN) && out_free;
   assign cmd_fire = cmd_valid && cmd_ready;

   assign rd_addr = (state_ff == ssd_pkg::BK_SCAN) ? idx_ff : IW'(cmd.pos);
   assign rd_key = keys_ff[rd_addr];
   assign pos_ok = (8'(cmd.pos) < 8'(count_ff));

   assign idx_onehot = CAPACITY'(1) << idx_ff;
   assign scan_here = remain_ff[idx_ff];
   assign scan_last = ((remain_ff & ~idx_onehot) == '0);
   assign scan_step = (state_ff == ssd_pkg::BK_SCAN) && (!scan_here || out_free);
   assign scan_emit = (state_ff == ssd_pkg::BK_SCAN) && scan_here && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssd_pkg::BK_RUN: begin
            if (cmd_fire && (cmd.op == ssd_pkg::OP_DIFF_END) && (|pending)) begin
               state_in = ssd_pkg::BK_SCAN;
            end
         end
         ssd_pkg::BK_SCAN: begin
            if (scan_emit && scan_last) begin
               state_in = ssd_pkg::BK_RUN;
            end
         end
         default: begin
            state_in = ssd_pkg::BK_RUN;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      marks_in = marks_ff;
      idx_in = idx_ff;
      remain_in = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in = rsp_ff;
      add_we = 1'b0;
      shift_en = 1'b0;
      if (cmd_fire) begin
         rsp_valid_in = 1'b1;
         rsp_in = '0;
         rsp_in.last = 1'b1;
         rsp_in.count = ssd_pkg::COUNT_W'(count_ff);
         case (cmd.op)
            ssd_pkg::OP_ADD: begin
               if (hit_any) begin
                  rsp_in.status = ssd_pkg::ST_MISS;
                  rsp_in.found = 1'b1;
                  rsp_in.position = ssd_pkg::POS_W'(hit_pos);
               end else if (full) begin
                  rsp_in.status = ssd_pkg::ST_FULL;
               end else begin
                  add_we = 1'b1;
                  count_in = count_ff + CW'(1);
                  marks_in[IW'(count_ff)] = 1'b0;
                  rsp_in.position = ssd_pkg::POS_W'(count_ff);
                  rsp_in.count = ssd_pkg::COUNT_W'(count_in);
               end
            end
            ssd_pkg::OP_REMOVE: begin
               if (hit_any) begin
                  // compaction: everything above the hit moves down one place
                  shift_en = 1'b1;
                  marks_in = (marks_ff & ~ge_mask) | ((marks_ff >> 1) & ge_mask);
                  count_in = count_ff - CW'(1);
                  rsp_in.found = 1'b1;
                  rsp_in.position = ssd_pkg::POS_W'(hit_pos);
                  rsp_in.count = ssd_pkg::COUNT_W'(count_in);
               end else begin
                  rsp_in.status = ssd_pkg::ST_MISS;
               end
            end
            ssd_pkg::OP_LOOKUP: begin
               if (hit_any) begin
                  rsp_in.found = 1'b1;
                  rsp_in.position = ssd_pkg::POS_W'(hit_pos);
               end else begin
                  rsp_in.status = ssd_pkg::ST_MISS;
               end
            end
            ssd_pkg::OP_READ: begin
               if (pos_ok) begin
                  rsp_in.position = cmd.pos;
                  rsp_in.key = ssd_pkg::KEY_W'(rd_key);
               end else begin
                  rsp_in.status = ssd_pkg::ST_BAD_POS;
               end
            end
            ssd_pkg::OP_DIFF_ELEM: begin
               if (hit_any) begin
                  marks_in = marks_ff | hit;
                  rsp_in.found = 1'b1;
                  rsp_in.position = ssd_pkg::POS_W'(hit_pos);
               end else begin
                  rsp_in.key = ssd_pkg::KEY_W'(cmd_key);
                  rsp_in.diff_list = ssd_pkg::DL_OTHER;
               end
            end
            ssd_pkg::OP_DIFF_END: begin
               if (|pending) begin
                  rsp_valid_in = 1'b0;
                  idx_in = '0;
                  remain_in = pending;
               end else begin
                  marks_in = '0;
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end else if (scan_step) begin
         remain_in = remain_ff & ~idx_onehot;
         idx_in = idx_ff + IW'(1);
         if (scan_emit) begin
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.position = ssd_pkg::POS_W'(idx_ff);
            rsp_in.key = ssd_pkg::KEY_W'(rd_key);
            rsp_in.diff_list = ssd_pkg::DL_OURS;
            rsp_in.last = scan_last;
            rsp_in.count = ssd_pkg::COUNT_W'(count_ff);
            if (scan_last) begin
               marks_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssd_pkg::BK_RUN;
         count_ff <= '0;
         marks_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         marks_ff <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      remain_ff <= remain_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (add_we) begin
         keys_ff[IW'(count_ff)] <= cmd_key;
      end
      if (shift_en) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (ge_mask[i]) begin
               keys_ff[i] <= keys_ff[i + 1];
            end
         end
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = rsp_ff.status;
   assign rsp_bus.found = rsp_ff.found;
   assign rsp_bus.position_out = rsp_ff.position;
   assign rsp_bus.key_out = rsp_ff.key;
   assign rsp_bus.diff_list = rsp_ff.diff_list;
   assign rsp_bus.last = rsp_ff.last;
   assign rsp_bus.count = rsp_ff.count;

   `SSD_ASSERT(count_in_range, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `SSD_ASSERT(keys_unique, clock, reset, !cmd_valid || $onehot0(hit), "key held twice")
   `SSD_ASSERT(marks_below_count, clock, reset, (marks_ff & ~valid_mask) == '0, "stale mark")
   `SSD_ASSERT(scan_has_work, clock, reset, (state_ff == ssd_pkg::BK_RUN) || (|remain_ff), "empty scan")
   `SSD_ASSERT_NEXT(add_grows, clock, reset, add_we, count_ff == $past(count_ff) + CW'(1), "add lost")

endmodule
